// ===== sv/fpfa_pkg.sv =====
// package for the fixed partition fit allocator
// item types, codes and the partition size function; no dependencies
package fpfa_pkg;

  localparam int PARTITIONS   = 1024;
  localparam int SIZE_CLASSES = 4;
  localparam int IDX_W        = 10;
  localparam int SIZE_W       = 3;
  localparam int POL_W        = 2;
  localparam int STATUS_W     = 2;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FR = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [IDX_W-1:0]  release_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    granted_index;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // size class of a partition: equal index bands, sizes from 1 upward
  function automatic logic [SIZE_W-1:0] part_size(input logic [IDX_W-1:0] idx);
    int unsigned prod;
    prod = int'(idx) * SIZE_CLASSES;
    return SIZE_W'(prod / PARTITIONS + 1);
  endfunction

endpackage

// ===== sv/fixed_partition_fit_allocator_core.sv =====
// fixed partition allocator core: free list walk with first, best or worst fit
// link and free-flag state in two synchronous memories; uses fpfa_pkg
//
//   port group      dir   signals                       handshake
//   command         in    start, request (in_item_t)    taken when start && !busy
//   result          out   done, result (out_item_t)     one-cycle strobe, no stall
//   configuration   in    cfg_valid, cfg_data           written when cfg_valid && cfg_ready
//
// after rst an initialisation pass over all PARTITIONS entries (1024) fills both memories;
// busy stays high during it, configuration writes are taken throughout.
// allocate: walks the free-list entries one per cycle (up to PARTITIONS) in S_WALK, then
// S_COMMIT; done rises the cycle after commit. an empty list answers at once.
// release: reads the free flag for S_REL, done the cycle after.
// the list walk is bound by the registered read of the link memory.
module fixed_partition_fit_allocator_core
  import fpfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         request,
  output logic             done,
  output out_item_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POL_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_WALK   = 5'b00100,
    S_COMMIT = 5'b01000,
    S_REL    = 5'b10000
  } state_t;

  state_t state;

  logic [POL_W-1:0]  fit_policy;
  logic [IDX_W-1:0]  list_head;
  logic [IDX_W-1:0]  list_tail;
  logic              list_empty;
  logic [IDX_W-1:0]  init_idx;

  // walk registers
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  prev;
  logic [IDX_W-1:0]  steps;
  logic [SIZE_W-1:0] req;
  logic              found;
  logic [IDX_W-1:0]  best;
  logic [IDX_W-1:0]  best_prev;
  logic [IDX_W-1:0]  best_next;
  logic [SIZE_W-1:0] best_slack;
  logic              best_at_head;
  logic [IDX_W-1:0]  rel_idx;

  // memories
  logic [IDX_W-1:0] link_mem [PARTITIONS];
  logic             free_mem [PARTITIONS];
  logic [IDX_W-1:0] link_rdata;
  logic             free_rdata;
  logic [IDX_W-1:0] link_raddr;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;
  logic             free_we;
  logic [IDX_W-1:0] free_waddr;
  logic             free_wdata;

  logic              accept;
  logic [SIZE_W-1:0] cur_size;
  logic              fits;
  logic [SIZE_W-1:0] slack;
  logic              first_pol;
  logic              take;
  logic              walk_end;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign cur_size  = part_size(cur);
  assign fits      = (cur_size >= req);
  assign slack     = cur_size - req;
  assign first_pol = (fit_policy != POL_BEST) && (fit_policy != POL_WORST);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (fit_policy == POL_BEST) begin
        take = (slack < best_slack);
      end else if (fit_policy == POL_WORST) begin
        take = (slack > best_slack);
      end
    end
  end

  assign walk_end = (fits && first_pol) || (cur == list_tail) ||
                    (steps == IDX_W'(PARTITIONS - 1));

  // read address: head outside the walk, so it is ready on accept; during the walk follow the link just read
  always_comb begin
    if (state == S_WALK) begin
      link_raddr = link_rdata;
    end else begin
      link_raddr = list_head;
    end
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = init_idx;
    link_wdata = '0;
    free_we    = 1'b0;
    free_waddr = init_idx;
    free_wdata = 1'b1;
    case (state)
      S_INIT: begin
        link_we    = 1'b1;
        link_wdata = (init_idx == IDX_W'(PARTITIONS - 1)) ? '0 : init_idx + 1'b1;
        free_we    = 1'b1;
      end
      S_COMMIT: begin
        if (found) begin
          free_we    = 1'b1;
          free_waddr = best;
          free_wdata = 1'b0;
          if (!best_at_head) begin
            link_we    = 1'b1;
            link_waddr = best_prev;
            link_wdata = best_next;
          end
        end
      end
      S_REL: begin
        if (!free_rdata) begin
          free_we    = 1'b1;
          free_waddr = rel_idx;
          if (!list_empty) begin
            link_we    = 1'b1;
            link_waddr = list_tail;
            link_wdata = rel_idx;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    free_rdata <= free_mem[request.release_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      fit_policy <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      list_head  <= '0;
      list_tail  <= IDX_W'(PARTITIONS - 1);
      list_empty <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == IDX_W'(PARTITIONS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (request.opcode == OP_RELEASE) begin
              rel_idx <= request.release_index;
              state   <= S_REL;
            end else if (list_empty) begin
              result.granted_index <= '0;
              result.status        <= ST_NO_FIT;
              done                 <= 1'b1;
            end else begin
              cur   <= list_head;
              prev  <= '0;
              steps <= '0;
              req   <= request.request_size;
              found <= 1'b0;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (take) begin
            found        <= 1'b1;
            best         <= cur;
            best_prev    <= prev;
            best_next    <= link_rdata;
            best_slack   <= slack;
            best_at_head <= (steps == '0);
          end
          if (walk_end) begin
            state <= S_COMMIT;
          end else begin
            prev  <= cur;
            cur   <= link_rdata;
            steps <= steps + 1'b1;
          end
        end
        S_COMMIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (found) begin
            result.granted_index <= best;
            result.status        <= ST_OK;
            if (best_at_head) begin
              if (list_head == list_tail) begin
                list_empty <= 1'b1;
              end else begin
                list_head <= best_next;
              end
            end else if (best == list_tail) begin
              list_tail <= best_prev;
            end
          end else begin
            result.granted_index <= '0;
            result.status        <= ST_NO_FIT;
          end
        end
        S_REL: begin
          done                 <= 1'b1;
          state                <= S_IDLE;
          result.granted_index <= '0;
          if (free_rdata) begin
            result.status <= ST_ALREADY_FR;
          end else begin
            result.status <= ST_OK;
            list_tail     <= rel_idx;
            if (list_empty) begin
              list_head  <= rel_idx;
              list_empty <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/fpfa_checker.sv =====
// checker for the fixed partition fit allocator: keeps its own free list and policy,
// forecasts each grant or release outcome and compares it with the result strobe
// uses fpfa_pkg for item types, codes and sizes
module fpfa_checker
  import fpfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         request,
  input  logic             done,
  input  out_item_t        result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [POL_W-1:0] cfg_data,
  input  logic             run_over,
  output int               fail_count
);

  logic [IDX_W-1:0] link_mem [PARTITIONS];
  bit               free_map [PARTITIONS];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  bit               list_gone;
  logic [POL_W-1:0] policy;
  out_item_t        grant_forecast [$];
  bit               tallied;

  function automatic out_item_t forecast_outcome(input in_item_t it);
    out_item_t   r;
    int unsigned cur, prev, pick, pick_prev, sz, slack, pick_slack;
    bit          got, pick_head, take;
    r.granted_index = '0;
    r.status        = ST_OK;
    if (it.opcode == OP_RELEASE) begin
      cur = it.release_index;
      if (free_map[cur]) begin
        r.status = ST_ALREADY_FR;
      end else begin
        free_map[cur] = 1'b1;
        if (list_gone) begin
          head      = IDX_W'(cur);
          tail      = IDX_W'(cur);
          list_gone = 1'b0;
        end else begin
          link_mem[tail] = IDX_W'(cur);
          tail           = IDX_W'(cur);
        end
      end
      return r;
    end
    r.status = ST_NO_FIT;
    if (list_gone) return r;
    cur        = head;
    prev       = 0;
    got        = 1'b0;
    pick       = 0;
    pick_prev  = 0;
    pick_head  = 1'b0;
    pick_slack = 0;
    for (int n = 0; n < PARTITIONS; n++) begin
      sz = cur * SIZE_CLASSES / PARTITIONS + 1;
      if (sz >= it.request_size) begin
        slack = sz - it.request_size;
        if (!got) take = 1'b1;
        else if (policy == POL_BEST) take = slack < pick_slack;
        else if (policy == POL_WORST) take = slack > pick_slack;
        else take = 1'b0;
        if (take) begin
          got        = 1'b1;
          pick       = cur;
          pick_prev  = prev;
          pick_head  = (n == 0);
          pick_slack = slack;
        end
        // first fit, and the spare policy code, stop at the first candidate
        if (policy != POL_BEST && policy != POL_WORST) break;
      end
      if (cur == tail) break;
      prev = cur;
      cur  = link_mem[cur];
    end
    if (!got) return r;
    if (pick_head) begin
      if (head == tail) list_gone = 1'b1;
      else head = link_mem[head];
    end else begin
      link_mem[pick_prev] = link_mem[pick];
      if (pick == tail) tail = IDX_W'(pick_prev);
    end
    free_map[pick]  = 1'b0;
    r.granted_index = IDX_W'(pick);
    r.status        = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        link_mem[i] = IDX_W'((i + 1) % PARTITIONS);
        free_map[i] = 1'b1;
      end
      head      = '0;
      tail      = IDX_W'(PARTITIONS - 1);
      list_gone = 1'b0;
      policy    = POL_FIRST;
      grant_forecast.delete();
      tallied    = 1'b0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) policy = cfg_data;
      // compare before taking a new item so a same-edge accept cannot match
      if (done) begin
        if (grant_forecast.size() == 0) begin
          $display("%0t result with no item waiting: granted_index %0d status %0d",
                   $time, result.granted_index, result.status);
          errs++;
        end else begin
          want = grant_forecast.pop_front();
          if (result.granted_index !== want.granted_index) begin
            $display("%0t granted_index expected %0d actual %0d",
                     $time, want.granted_index, result.granted_index);
            errs++;
          end
          if (result.status !== want.status) begin
            $display("%0t status expected %0d actual %0d", $time, want.status, result.status);
            errs++;
          end
        end
      end
      if (start && !busy) grant_forecast.push_back(forecast_outcome(request));
      if (run_over && !tallied) begin
        tallied = 1'b1;
        if (grant_forecast.size() != 0) begin
          $display("%0t %0d results never arrived, oldest expected index %0d status %0d",
                   $time, grant_forecast.size(), grant_forecast[0].granted_index,
                   grant_forecast[0].status);
          errs++;
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// top of the allocator testbench: clock, reset, policy writes and command stimulus
// depends on fpfa_pkg, fixed_partition_fit_allocator_core and fpfa_checker
module tb_top;
  import fpfa_pkg::*;

  localparam logic [POL_W-1:0] POL_SPARE   = 2'd3;
  localparam int               STALL_LIMIT = 20000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  in_item_t         request;
  logic             done;
  out_item_t        result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [POL_W-1:0] cfg_data;
  logic             run_over;
  int               fail_count;

  logic             ops_in_flight [$];
  logic [IDX_W-1:0] owned_parts [$];
  int               calm_left;
  int               idle_cycles;

  fixed_partition_fit_allocator_core dut (.*);
  fpfa_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // remember what was granted so releases can hit allocated partitions
  always @(posedge clk) begin
    if (!rst && done && ops_in_flight.size() != 0) begin
      if (ops_in_flight.pop_front() == OP_ALLOC && result.status == ST_OK)
        owned_parts.push_back(result.granted_index);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic in_item_t alloc_item(input int unsigned want);
    in_item_t it;
    it.opcode        = OP_ALLOC;
    it.request_size  = SIZE_W'(want);
    it.release_index = IDX_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t release_item(input int unsigned idx);
    in_item_t it;
    it.opcode        = OP_RELEASE;
    it.request_size  = SIZE_W'($urandom);
    it.release_index = IDX_W'(idx);
    return it;
  endfunction

  task automatic issue(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(5, 20);
    else gap = $urandom_range(0, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= it;
    do @(posedge clk); while (busy);
    ops_in_flight.push_back(it.opcode);
  endtask

  // hold off until every item has answered
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ops_in_flight.size() != 0) @(posedge clk);
  endtask

  task automatic set_policy(input logic [POL_W-1:0] pol);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= pol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_mix(input int count);
    int               roll;
    int               pick;
    int               pause_at;
    logic [IDX_W-1:0] last_freed;
    pause_at   = $urandom_range(0, count - 1);
    last_freed = IDX_W'($urandom);
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) settle();
      roll = $urandom_range(0, 99);
      if (roll < 42) begin
        issue(alloc_item($urandom_range(1, 4)));
      end else if (roll < 50) begin
        issue(alloc_item($urandom_range(0, 7)));
      end else if (roll < 85 && owned_parts.size() != 0) begin
        pick       = $urandom_range(0, owned_parts.size() - 1);
        last_freed = owned_parts[pick];
        owned_parts.delete(pick);
        issue(release_item(last_freed));
      end else if (roll < 93) begin
        // double release of the last partition handed back
        issue(release_item(last_freed));
      end else begin
        issue(release_item($urandom_range(0, PARTITIONS - 1)));
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    request   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    run_over  <= 1'b0;
    calm_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: size extremes, oversize requests, double release, every policy
    set_policy(POL_FIRST);
    issue(alloc_item(0));
    issue(alloc_item(4));
    issue(alloc_item(7));
    issue(alloc_item(5));
    issue(release_item(0));
    issue(release_item(0));
    issue(release_item(PARTITIONS - 1));
    issue(alloc_item(2));
    set_policy(POL_BEST);
    issue(alloc_item(1));
    issue(alloc_item(3));
    issue(alloc_item(0));
    set_policy(POL_WORST);
    issue(alloc_item(1));
    issue(alloc_item(4));
    issue(alloc_item(0));
    set_policy(POL_SPARE);
    issue(alloc_item(2));
    issue(release_item(768));
    issue(release_item(256));
    issue(release_item(512));
    issue(release_item(768));

    // random traffic on a mostly full list under each policy
    set_policy(POL_BEST);
    random_mix(70);
    set_policy(POL_WORST);
    random_mix(70);
    set_policy(POL_FIRST);
    random_mix(70);
    set_policy(POL_SPARE);
    random_mix(70);

    // drain the largest size class past its last entry, then misses are common
    set_policy(POL_FIRST);
    repeat (PARTITIONS / 4 + 6) issue(alloc_item(4));
    set_policy(POL_BEST);
    random_mix(10);
    set_policy(POL_WORST);
    random_mix(10);

    settle();
    repeat (PARTITIONS + 8) @(posedge clk);
    run_over <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fpfa_pkg.sv
sv/fixed_partition_fit_allocator_core.sv
dv/fpfa_checker.sv
dv/tb_top.sv
